// ===== rtl/core/pmb_pkg.sv =====
// Shared types and constants of the page bitmap builder.
package pmb_pkg;

    localparam int WORD_W       = 64;
    localparam int BIT_IDX_W    = 6;
    localparam int WORD_INDEX_W = 10;
    localparam int TYPE_W       = 32;

    localparam logic [TYPE_W-1:0] USABLE_TYPE = 32'd1;

    localparam logic ACT_APPLY = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXTENT,
        ST_MARK,
        ST_READ,
        ST_DONE
    } pmb_state_t;

    // Commands from the sequencer to the bitmap memory.
    typedef struct packed {
        logic mark;
        logic read;
        logic used;
    } pmb_bm_cmd_t;

    typedef struct packed {
        logic clearing;
        logic done;
    } pmb_bm_stat_t;

    typedef struct packed {
        logic done;
        logic empty;
    } pmb_ext_stat_t;

endpackage

// ===== rtl/core/pmb_extent.sv =====
// Page rounding, page range clipping and the running top and byte totals.
module pmb_extent #(
    parameter int PAGE_SHIFT   = 12,
    parameter int BITMAP_WORDS = 1024,
    parameter int AW           = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [63:0]            ebase,
    input  logic [63:0]            elen,
    input  logic                   usable,
    output logic [63:0]            mem_ceiling,
    output logic [63:0]            usable_top,
    output logic [63:0]            usable_bytes,
    output logic [AW-1:0]          fw_word,
    output logic [AW-1:0]          lw_word,
    output logic [5:0]             lo_bit,
    output logic [5:0]             hi_bit,
    output pmb_pkg::pmb_ext_stat_t stat
);
    import pmb_pkg::*;

    localparam int TW = $clog2(BITMAP_WORDS * 64 + 1);
    localparam logic [63:0] PAGE_MASK   = (64'd1 << PAGE_SHIFT) - 64'd1;
    localparam logic [63:0] TOTAL_PAGES = 64'(BITMAP_WORDS) << 6;

    logic [3:0]    stg_reg;
    logic [63:0]   sum_reg;
    logic [63:0]   base_rnd_reg;
    logic [63:0]   end_rnd_reg;
    logic          usable_reg;
    logic [TW-1:0] first_reg;
    logic [TW-1:0] lim_reg;
    logic [TW-1:0] lm1_reg;
    logic          empty_reg;
    logic [63:0]   mem_top_reg;
    logic [63:0]   use_top_reg;
    logic [63:0]   use_sum_reg;

    logic [63:0]   base_pg;
    logic [63:0]   end_pg;
    logic [TW-1:0] first_next;
    logic [TW-1:0] lim_next;

    assign base_pg    = base_rnd_reg >> PAGE_SHIFT;
    assign end_pg     = end_rnd_reg >> PAGE_SHIFT;
    assign first_next = (base_pg > TOTAL_PAGES) ? TOTAL_PAGES[TW-1:0] : base_pg[TW-1:0];
    assign lim_next   = (end_pg > TOTAL_PAGES) ? TOTAL_PAGES[TW-1:0] : end_pg[TW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_reg     <= '0;
            mem_top_reg <= '0;
            use_top_reg <= '0;
            use_sum_reg <= '0;
        end else begin
            stg_reg <= {stg_reg[2:0], start};
            if (start && usable) begin
                use_sum_reg <= use_sum_reg + elen;
            end
            if (stg_reg[1]) begin
                if (end_rnd_reg > mem_top_reg) begin
                    mem_top_reg <= end_rnd_reg;
                end
                if (usable_reg && (end_rnd_reg > use_top_reg)) begin
                    use_top_reg <= end_rnd_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sum_reg      <= ebase + elen;
            base_rnd_reg <= (ebase + PAGE_MASK) & ~PAGE_MASK;
            usable_reg   <= usable;
        end
        if (stg_reg[0]) begin
            end_rnd_reg <= (sum_reg + PAGE_MASK) & ~PAGE_MASK;
            first_reg   <= first_next;
        end
        if (stg_reg[1]) begin
            lim_reg <= lim_next;
        end
        if (stg_reg[2]) begin
            // Both ends are clipped to the bitmap, so an empty range covers the
            // case of a region that lies wholly above the last page.
            empty_reg <= (first_reg >= lim_reg);
            lm1_reg   <= lim_reg - TW'(1);
        end
    end

    assign mem_ceiling  = mem_top_reg;
    assign usable_top   = use_top_reg;
    assign usable_bytes = use_sum_reg;
    assign fw_word      = first_reg[AW+5:6];
    assign lo_bit       = first_reg[5:0];
    assign lw_word      = lm1_reg[AW+5:6];
    assign hi_bit       = lm1_reg[5:0];
    assign stat.done    = stg_reg[3];
    assign stat.empty   = empty_reg;

endmodule

// ===== rtl/core/pmb_bitmap.sv =====
// Page bitmap memory with the reset fill pass and the word read-modify-write walk.
module pmb_bitmap #(
    parameter int BITMAP_WORDS = 1024,
    parameter int AW           = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pmb_pkg::pmb_bm_cmd_t  cmd,
    input  logic [AW-1:0]         fw_word,
    input  logic [AW-1:0]         lw_word,
    input  logic [5:0]            lo_bit,
    input  logic [5:0]            hi_bit,
    input  logic [AW-1:0]         rd_addr,
    output logic [63:0]           rd_word,
    output pmb_pkg::pmb_bm_stat_t stat
);
    import pmb_pkg::*;

    logic [WORD_W-1:0] mem [BITMAP_WORDS];

    logic              clr_active_reg;
    logic [AW-1:0]     clr_addr_reg;
    logic              walk_active_reg;
    logic [AW-1:0]     walk_reg;
    logic              used_reg;
    logic              wb_valid_reg;
    logic              wb_last_reg;
    logic [AW-1:0]     wb_addr_reg;
    logic [WORD_W-1:0] wb_mask_reg;
    logic              rd_pend_reg;
    logic [WORD_W-1:0] rdata_reg;

    logic [5:0]        lo_sel;
    logic [5:0]        hi_sel;
    logic [WORD_W-1:0] mask;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;

    always_comb begin
        lo_sel = (walk_reg == fw_word) ? lo_bit : 6'd0;
        hi_sel = (walk_reg == lw_word) ? hi_bit : 6'd63;
        mask   = ({WORD_W{1'b1}} << lo_sel) & ({WORD_W{1'b1}} >> (6'd63 - hi_sel));
    end

    always_comb begin
        mem_we    = clr_active_reg | wb_valid_reg;
        mem_waddr = clr_active_reg ? clr_addr_reg : wb_addr_reg;
        if (clr_active_reg) begin
            mem_wdata = {WORD_W{1'b1}};
        end else if (used_reg) begin
            mem_wdata = rdata_reg | wb_mask_reg;
        end else begin
            mem_wdata = rdata_reg & ~wb_mask_reg;
        end
        mem_raddr = walk_active_reg ? walk_reg : rd_addr;
    end

    // The walk reads word w+1 while word w is written back, so the two never
    // meet on one entry.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg  <= 1'b1;
            clr_addr_reg    <= '0;
            walk_active_reg <= 1'b0;
            wb_valid_reg    <= 1'b0;
            rd_pend_reg     <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                if (clr_addr_reg == AW'(BITMAP_WORDS - 1)) begin
                    clr_active_reg <= 1'b0;
                end else begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                end
            end
            rd_pend_reg  <= cmd.read;
            wb_valid_reg <= walk_active_reg;
            if (cmd.mark) begin
                walk_active_reg <= 1'b1;
            end else if (walk_active_reg && (walk_reg == lw_word)) begin
                walk_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mark) begin
            walk_reg <= fw_word;
            used_reg <= cmd.used;
        end else if (walk_active_reg) begin
            walk_reg <= walk_reg + AW'(1);
        end
        wb_addr_reg <= walk_reg;
        wb_mask_reg <= mask;
        wb_last_reg <= (walk_reg == lw_word);
    end

    assign rd_word       = rdata_reg;
    assign stat.clearing = clr_active_reg;
    assign stat.done     = rd_pend_reg | (wb_valid_reg & wb_last_reg);

endmodule

// ===== rtl/core/memory_map_page_bitmap_builder_top.sv =====
// Apply items pass the extent stages and then a walk over the bitmap words that their range
// touches (no walk when empty); a read fetches one word (no fetch when out of range).
// Throughput: one item at a time; the next item can be taken in the cycle after the result is
// loaded; the walk over the bitmap memory steps one 64-page word per cycle.
// Reset: tops and byte total clear at once; the bitmap is then filled with ones,
// one word a cycle, and no item is taken until the fill ends.
module memory_map_page_bitmap_builder_top #(
    parameter int PAGE_SHIFT   = 12,
    parameter int BITMAP_WORDS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [63:0] s_entry_base,
    input  logic [63:0] s_entry_length,
    input  logic [31:0] s_region_type,
    input  logic [9:0]  s_word_index,
    input  logic        s_last_entry,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_bitmap_word,
    output logic [63:0] m_mem_ceiling,
    output logic [63:0] m_usable_top,
    output logic [63:0] m_usable_bytes,
    output logic        m_map_done
);
    import pmb_pkg::*;

    localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

    pmb_state_t    state_reg, state_next;
    logic [63:0]   word_reg;
    logic          used_reg;
    logic          done_flag_reg;
    logic          m_valid_reg;
    logic [63:0]   m_word_reg;
    logic [63:0]   m_mem_top_reg;
    logic [63:0]   m_use_top_reg;
    logic [63:0]   m_use_bytes_reg;
    logic          m_done_reg;

    logic          accept;
    logic          in_range;
    logic          ext_start;
    logic          load_out;
    logic [AW+WORD_INDEX_W-1:0] idx_ext;
    logic [AW-1:0] rd_addr;

    pmb_bm_cmd_t   bm_cmd;
    pmb_bm_stat_t  bm_stat;
    pmb_ext_stat_t ext_stat;
    logic [63:0]   mem_ceiling;
    logic [63:0]   usable_top;
    logic [63:0]   usable_bytes;
    logic [AW-1:0] fw_word;
    logic [AW-1:0] lw_word;
    logic [5:0]    lo_bit;
    logic [5:0]    hi_bit;
    logic [63:0]   rd_word;

    assign accept    = s_valid & s_ready;
    assign in_range  = (32'(s_word_index) < 32'(BITMAP_WORDS));
    assign idx_ext   = (AW + WORD_INDEX_W)'(s_word_index);
    assign rd_addr   = idx_ext[AW-1:0];
    assign ext_start = accept && (s_action == ACT_APPLY);

    pmb_extent #(
        .PAGE_SHIFT   (PAGE_SHIFT),
        .BITMAP_WORDS (BITMAP_WORDS),
        .AW           (AW)
    ) u_extent (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (ext_start),
        .ebase        (s_entry_base),
        .elen         (s_entry_length),
        .usable       (s_region_type == USABLE_TYPE),
        .mem_ceiling  (mem_ceiling),
        .usable_top   (usable_top),
        .usable_bytes (usable_bytes),
        .fw_word      (fw_word),
        .lw_word      (lw_word),
        .lo_bit       (lo_bit),
        .hi_bit       (hi_bit),
        .stat         (ext_stat)
    );

    pmb_bitmap #(
        .BITMAP_WORDS (BITMAP_WORDS),
        .AW           (AW)
    ) u_bitmap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (bm_cmd),
        .fw_word (fw_word),
        .lw_word (lw_word),
        .lo_bit  (lo_bit),
        .hi_bit  (hi_bit),
        .rd_addr (rd_addr),
        .rd_word (rd_word),
        .stat    (bm_stat)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_action == ACT_APPLY) begin
                        state_next = ST_EXTENT;
                    end else if (in_range) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_EXTENT: begin
                if (ext_stat.done) begin
                    state_next = ext_stat.empty ? ST_DONE : ST_MARK;
                end
            end
            ST_MARK, ST_READ: begin
                if (bm_stat.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = (state_reg == ST_IDLE) && !bm_stat.clearing;
        bm_cmd.mark = (state_reg == ST_EXTENT) && ext_stat.done && !ext_stat.empty;
        bm_cmd.read = accept && (s_action == ACT_READ) && in_range;
        bm_cmd.used = used_reg;
        load_out    = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            word_reg      <= '0;
            used_reg      <= (s_region_type != USABLE_TYPE);
            done_flag_reg <= (s_action == ACT_APPLY) ? s_last_entry : 1'b0;
        end else if ((state_reg == ST_READ) && bm_stat.done) begin
            word_reg <= rd_word;
        end
        if (load_out) begin
            m_word_reg      <= word_reg;
            m_mem_top_reg   <= mem_ceiling;
            m_use_top_reg   <= usable_top;
            m_use_bytes_reg <= usable_bytes;
            m_done_reg      <= done_flag_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_bitmap_word  = m_word_reg;
    assign m_mem_ceiling  = m_mem_top_reg;
    assign m_usable_top   = m_use_top_reg;
    assign m_usable_bytes = m_use_bytes_reg;
    assign m_map_done     = m_done_reg;

    a_no_accept_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        bm_stat.clearing |-> !s_ready)
        else $error("item taken during the bitmap fill pass");

    a_bm_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        bm_stat.done |-> (state_reg == ST_MARK || state_reg == ST_READ))
        else $error("bitmap finished outside a mark or read");

    a_ext_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ext_stat.done |-> (state_reg == ST_EXTENT))
        else $error("extent finished outside its state");

    a_tops_order: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_ceiling >= usable_top)
        else $error("usable top above memory top");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench: memory map entries and bitmap reads against a bitmap mirror.
module tb;
    import pmb_pkg::*;

    localparam int PAGE_SHIFT      = 12;
    localparam int BITMAP_WORDS    = 1024;
    localparam longint TOTAL_PAGES = BITMAP_WORDS * 64;
    localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;

    // Non-usable region type codes as firmware reports them.
    localparam logic [31:0] TYPE_RESERVED = 32'd2;
    localparam logic [31:0] TYPE_ACPI     = 32'd3;
    localparam logic [31:0] TYPE_NVS      = 32'd4;
    localparam logic [31:0] TYPE_BAD      = 32'd5;

    localparam int DIR_ROWS        = 25;
    localparam int RANDOM_ITEMS    = 375;
    localparam int CALM_ITEMS      = 60;
    localparam int HOLD_AT         = 150;
    localparam int PAUSE_AT        = 260;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 64;
    localparam int WATCHDOG_CYCLES = 20000;

    typedef struct packed {
        logic        action;
        logic [63:0] base;
        logic [63:0] length;
        logic [31:0] rtype;
        logic [9:0]  idx;
        logic        last;
    } map_item_t;

    typedef struct packed {
        logic [63:0] word;
        logic [63:0] mem_top;
        logic [63:0] use_top;
        logic [63:0] use_bytes;
        logic        done;
    } map_result_t;

    typedef struct packed {
        map_item_t   item;
        logic        typed;
        map_result_t want;
    } dir_row_t;

    localparam map_result_t NO_RES = '0;
    localparam logic [63:0] ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

    // Rows with typed set carry a hand-written result; the rest go through the mirror.
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{'{ACT_READ, 64'd0, 64'd0, 32'd0, 10'd0, 1'b0}, 1'b1,
          '{ONES, 64'd0, 64'd0, 64'd0, 1'b0}},
        '{'{ACT_READ, ONES, ONES, 32'hFFFF_FFFF, 10'd1023, 1'b1}, 1'b1,
          '{ONES, 64'd0, 64'd0, 64'd0, 1'b0}},
        '{'{ACT_APPLY, 64'd0, 64'h1000, USABLE_TYPE, 10'd0, 1'b0}, 1'b1,
          '{64'd0, 64'h1000, 64'h1000, 64'h1000, 1'b0}},
        '{'{ACT_READ, 64'd0, 64'd0, 32'd0, 10'd0, 1'b0}, 1'b1,
          '{64'hFFFF_FFFF_FFFF_FFFE, 64'h1000, 64'h1000, 64'h1000, 1'b0}},
        '{'{ACT_APPLY, 64'h1001, 64'h10, USABLE_TYPE, 10'd0, 1'b0}, 1'b0, NO_RES},
        '{'{ACT_APPLY, 64'd0, 64'h4_0000, USABLE_TYPE, 10'd0, 1'b0}, 1'b0, NO_RES},
        '{'{ACT_APPLY, 64'h3000, 64'h2000, TYPE_RESERVED, 10'd0, 1'b0}, 1'b0, NO_RES},
        '{'{ACT_APPLY, 64'h1_0000, 64'h5000, 32'hFFFF_FFFF, 10'd0, 1'b1}, 1'b0, NO_RES},
        '{'{ACT_READ, 64'd0, 64'd0, 32'd0, 10'd0, 1'b0}, 1'b0, NO_RES},
        '{'{ACT_APPLY, 64'hFFFF_FFFF_FFFF_F001, 64'hFFF, USABLE_TYPE, 10'd0, 1'b0},
          1'b0, NO_RES},
        '{'{ACT_APPLY, 64'hFFFF_FFFF_FFFF_FF00, 64'h2000, USABLE_TYPE, 10'd0, 1'b0},
          1'b0, NO_RES},
        '{'{ACT_APPLY, 64'd0, ONES, USABLE_TYPE, 10'd0, 1'b0}, 1'b0, NO_RES},
        '{'{ACT_APPLY, 64'h0FFF_0000, 64'h20_0000, TYPE_ACPI, 10'd0, 1'b0}, 1'b0, NO_RES},
        '{'{ACT_APPLY, 64'h1000_0000, 64'h1000, USABLE_TYPE, 10'd0, 1'b0}, 1'b0, NO_RES},
        '{'{ACT_READ, 64'd0, 64'd0, 32'd0, 10'd1023, 1'b0}, 1'b0, NO_RES},
        '{'{ACT_APPLY, 64'd0, 64'h1000_0000, USABLE_TYPE, 10'd0, 1'b0}, 1'b0, NO_RES},
        '{'{ACT_READ, 64'd0, 64'd0, 32'd0, 10'd512, 1'b0}, 1'b0, NO_RES},
        '{'{ACT_APPLY, 64'd0, 64'h1000_0000, 32'd0, 10'd0, 1'b0}, 1'b0, NO_RES},
        '{'{ACT_APPLY, 64'h40, 64'h1_0000, USABLE_TYPE, 10'd0, 1'b1}, 1'b0, NO_RES},
        '{'{ACT_READ, 64'd0, 64'd0, 32'd0, 10'd0, 1'b0}, 1'b0, NO_RES},
        '{'{ACT_APPLY, ONES, ONES, TYPE_NVS, 10'd0, 1'b0}, 1'b0, NO_RES},
        '{'{ACT_APPLY, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, TYPE_BAD,
            10'h2AA, 1'b1}, 1'b0, NO_RES},
        '{'{ACT_READ, 64'd0, 64'd0, 32'd0, 10'h155, 1'b0}, 1'b0, NO_RES},
        '{'{ACT_APPLY, 64'h0FFF_F000, 64'h1000, TYPE_RESERVED, 10'd0, 1'b0}, 1'b0, NO_RES},
        '{'{ACT_READ, 64'd0, 64'd0, 32'd0, 10'd1023, 1'b0}, 1'b0, NO_RES}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_action;
    logic [63:0] s_entry_base;
    logic [63:0] s_entry_length;
    logic [31:0] s_region_type;
    logic [9:0]  s_word_index;
    logic        s_last_entry;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_bitmap_word;
    logic [63:0] m_mem_ceiling;
    logic [63:0] m_usable_top;
    logic [63:0] m_usable_bytes;
    logic        m_map_done;

    // Mirror of the block's state.
    logic [63:0] bitmap_mirror [BITMAP_WORDS];
    logic [63:0] mem_top;
    logic [63:0] usable_top;
    logic [63:0] usable_sum;

    map_result_t pending_results [$];
    map_result_t oldest;
    int          fail_count;
    int          items_sent;
    int          idle_pct;
    int          quiet_cycles;
    bit          hold_req;

    memory_map_page_bitmap_builder_top #(
        .PAGE_SHIFT   (PAGE_SHIFT),
        .BITMAP_WORDS (BITMAP_WORDS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_entry_base   (s_entry_base),
        .s_entry_length (s_entry_length),
        .s_region_type  (s_region_type),
        .s_word_index   (s_word_index),
        .s_last_entry   (s_last_entry),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bitmap_word  (m_bitmap_word),
        .m_mem_ceiling  (m_mem_ceiling),
        .m_usable_top   (m_usable_top),
        .m_usable_bytes (m_usable_bytes),
        .m_map_done     (m_map_done)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Applies one item to the mirror and returns the result the block should give.
    function automatic map_result_t bitmap_step(input map_item_t it);
        map_result_t res;
        logic [63:0] rbase;
        logic [63:0] rend;
        logic [63:0] first_pg;
        logic [63:0] lim_pg;
        logic [63:0] mask;
        bit          usable;
        int          fw;
        int          lw;
        int          lo;
        int          hi;
        int          w;
        res = '0;
        if (it.action == ACT_APPLY) begin
            rbase  = (it.base + PAGE_MASK) & ~PAGE_MASK;
            rend   = (it.base + it.length + PAGE_MASK) & ~PAGE_MASK;
            usable = (it.rtype == USABLE_TYPE);
            if (rend > mem_top) mem_top = rend;
            if (usable) begin
                usable_sum = usable_sum + it.length;
                if (rend > usable_top) usable_top = rend;
            end
            first_pg = rbase >> PAGE_SHIFT;
            lim_pg   = rend >> PAGE_SHIFT;
            if (lim_pg > TOTAL_PAGES) lim_pg = TOTAL_PAGES;
            if (first_pg < lim_pg) begin
                fw = int'(first_pg >> 6);
                lw = int'((lim_pg - 64'd1) >> 6);
                for (w = fw; w <= lw; w++) begin
                    lo   = (w == fw) ? int'(first_pg[5:0]) : 0;
                    hi   = (w == lw) ? int'((lim_pg - 64'd1) & 64'd63) + 1 : 64;
                    mask = (ONES >> (64 - hi)) & (ONES << lo);
                    if (usable) bitmap_mirror[w] = bitmap_mirror[w] & ~mask;
                    else bitmap_mirror[w] = bitmap_mirror[w] | mask;
                end
            end
            res.done = it.last;
        end else begin
            res.word = bitmap_mirror[it.idx];
        end
        res.mem_top   = mem_top;
        res.use_top   = usable_top;
        res.use_bytes = usable_sum;
        return res;
    endfunction

    // Addresses mostly inside the bitmap, with some full-width and near-top values.
    function automatic map_item_t random_map_item();
        map_item_t it;
        it.action = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: it.base = 64'($urandom_range(0, 32'h1100_0000));
            6: it.base = 64'($urandom_range(0, 65600)) << PAGE_SHIFT;
            7, 8: it.base = {$urandom, $urandom};
            default: it.base = {32'hFFFF_FFFF, $urandom};
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: it.length = 64'($urandom_range(0, 32'h4_0000));
            5, 6: it.length = 64'($urandom_range(0, 32'h40_0000));
            7: it.length = 64'($urandom_range(0, 32'h1000_0000));
            8: it.length = {$urandom, $urandom};
            default: it.length = 64'($urandom_range(1, 8)) << PAGE_SHIFT;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: it.rtype = USABLE_TYPE;
            5, 6: begin
                case ($urandom_range(0, 3))
                    0: it.rtype = TYPE_RESERVED;
                    1: it.rtype = TYPE_ACPI;
                    2: it.rtype = TYPE_NVS;
                    default: it.rtype = TYPE_BAD;
                endcase
            end
            7: it.rtype = 32'd0;
            default: it.rtype = $urandom;
        endcase
        it.idx  = 10'($urandom_range(0, 1023));
        it.last = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic push_item(input map_item_t it, input bit typed, input map_result_t typed_res);
        map_result_t predicted;
        if (items_sent >= DIR_ROWS + RANDOM_ITEMS - CALM_ITEMS) begin
            idle_pct = 0;
        end else begin
            case ((items_sent / 50) % 3)
                0: idle_pct = 25;
                1: idle_pct = 0;
                default: idle_pct = 8;
            endcase
        end
        if (items_sent == HOLD_AT) hold_req = 1'b1;
        if (items_sent == PAUSE_AT) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge aclk);
        end else if ($urandom_range(0, 99) < idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 16)) @(negedge aclk);
        end
        @(negedge aclk);
        s_action       <= it.action;
        s_entry_base   <= it.base;
        s_entry_length <= it.length;
        s_region_type  <= it.rtype;
        s_word_index   <= it.idx;
        s_last_entry   <= it.last;
        s_valid        <= 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = bitmap_step(it);
        pending_results.push_back(typed ? typed_res : predicted);
        items_sent++;
    endtask

    initial begin
        int        row_n;
        int        n_entries;
        int        k;
        map_item_t it;
        for (row_n = 0; row_n < BITMAP_WORDS; row_n++) bitmap_mirror[row_n] = ONES;
        mem_top        = '0;
        usable_top     = '0;
        usable_sum     = '0;
        fail_count     = 0;
        items_sent     = 0;
        idle_pct       = 0;
        hold_req       = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_action       = ACT_APPLY;
        s_entry_base   = '0;
        s_entry_length = '0;
        s_region_type  = '0;
        s_word_index   = '0;
        s_last_entry   = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        for (row_n = 0; row_n < DIR_ROWS; row_n++)
            push_item(DIR_TABLE[row_n].item, DIR_TABLE[row_n].typed, DIR_TABLE[row_n].want);

        // Mostly whole maps (entries closed by a last entry, then reads), some stray items.
        while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) != 0) begin
                n_entries = $urandom_range(1, 8);
                for (k = 0; k < n_entries; k++) begin
                    it        = random_map_item();
                    it.action = ACT_APPLY;
                    it.last   = (k == n_entries - 1);
                    push_item(it, 1'b0, NO_RES);
                end
                repeat ($urandom_range(1, 4)) begin
                    it        = random_map_item();
                    it.action = ACT_READ;
                    push_item(it, 1'b0, NO_RES);
                end
            end else begin
                push_item(random_map_item(), 1'b0, NO_RES);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("memory_map_page_bitmap_builder_top: match");
        end else begin
            $display("memory_map_page_bitmap_builder_top: mismatch");
        end
        $finish;
    end

    // Result side: random back-pressure bursts plus one long hold requested by the sender.
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 1'b0;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 16)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %h got %h", $time, name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item: word %h mem_top %h usable_top %h bytes %h done %b",
                         $time, m_bitmap_word, m_mem_ceiling, m_usable_top, m_usable_bytes,
                         m_map_done);
                fail_count++;
            end else begin
                oldest = pending_results.pop_front();
                check_field("bitmap_word", oldest.word, m_bitmap_word);
                check_field("mem_ceiling", oldest.mem_top, m_mem_ceiling);
                check_field("usable_top", oldest.use_top, m_usable_top);
                check_field("usable_bytes", oldest.use_bytes, m_usable_bytes);
                check_field("map_done", 64'(oldest.done), 64'(m_map_done));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("memory_map_page_bitmap_builder_top: mismatch");
            $finish;
        end
    end

    initial quiet_cycles = 0;

endmodule
